// ===== src/qrnog_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrnog_pkg: shared types and helpers for the quad ring node order generator
// Holds the walk state, the segment codes and the start-of-sequence function.
// ----------------------------------------------------------------------------
package qrnog_pkg;

  // Highest element order the generator accepts; a write uses only the low four bits.
  localparam logic [3:0] MAX_ORDER = 4'd15;

  // Segment of the current ring that the walk is in.
  typedef enum logic [3:0] {
    SEG_CORNER_BL = 4'd0,
    SEG_CORNER_BR = 4'd1,
    SEG_CORNER_TR = 4'd2,
    SEG_CORNER_TL = 4'd3,
    SEG_EDGE_B    = 4'd4,
    SEG_EDGE_R    = 4'd5,
    SEG_EDGE_T    = 4'd6,
    SEG_EDGE_L    = 4'd7,
    SEG_CENTER    = 4'd8
  } seg_e;

  // Complete walk state carried from one word to the next.
  typedef struct packed {
    logic [3:0]      span;     // ring span k
    seg_e            seg;      // segment within the ring
    logic [3:0]      step;     // node count within an edge segment
    logic [5:0][7:0] corner;   // ring start indices
    logic [7:0]      pos;      // sequence position of the next word
    logic [7:0]      offset;   // grid index of the next edge node
  } walk_t;

  // One result word.
  typedef struct packed {
    logic [7:0] seq_pos;
    logic [7:0] grid_index;
    logic       last;
  } res_t;

  // Walk state at the start of a sequence for the given order.
  function automatic walk_t init_walk(input logic [3:0] order);
    walk_t      w;
    logic [4:0] n;
    logic [9:0] sq;
    logic [9:0] two_n;
    n           = {1'b0, order} + 5'd1;
    sq          = {5'd0, n} * {5'd0, n};
    two_n       = {4'd0, n, 1'b0};
    w.span      = order;
    w.seg       = SEG_CORNER_BL;
    w.step      = 4'd0;
    w.pos       = 8'd0;
    w.offset    = 8'd0;
    w.corner[0] = 8'd0;
    w.corner[1] = sq[7:0] - 8'd1;
    w.corner[2] = 8'd1;
    w.corner[3] = two_n[7:0] - 8'd1;
    w.corner[4] = sq[7:0] - 8'd2;
    w.corner[5] = sq[7:0] - two_n[7:0];
    return w;
  endfunction

endpackage

// ===== src/qrnog_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrnog_step: one step of the ring walk
// From the current walk state, works out the grid index of this node and the
// walk state for the next node, stepping corners, edges and the center and
// shrinking to the next inner ring when one is done.
// ----------------------------------------------------------------------------
module qrnog_step (
  input  logic [3:0]       order_i,
  input  logic             restart_i,
  input  qrnog_pkg::walk_t walk_i,
  output qrnog_pkg::walk_t walk_o,
  output qrnog_pkg::res_t  res_o
);

  qrnog_pkg::walk_t cur;
  qrnog_pkg::walk_t nxt;
  qrnog_pkg::walk_t restart_walk;
  logic [7:0]       n8;
  logic [7:0]       ord8;
  logic [7:0]       addr;
  logic             is_edge;
  logic             edge_more;
  logic             finish;
  logic [3:0]       seg_inc;

  assign restart_walk = qrnog_pkg::init_walk(order_i);
  assign ord8         = {4'd0, order_i};
  assign n8           = ord8 + 8'd1;
  assign cur          = restart_i ? restart_walk : walk_i;
  assign seg_inc      = cur.seg + 4'd1;

  // Grid index of this node.
  always_comb begin
    case (cur.seg)
      qrnog_pkg::SEG_CORNER_BL: addr = cur.corner[0];
      qrnog_pkg::SEG_CORNER_BR: addr = cur.corner[0] + {4'd0, cur.span};
      qrnog_pkg::SEG_CORNER_TR: addr = cur.corner[1];
      qrnog_pkg::SEG_CORNER_TL: addr = cur.corner[1] - {4'd0, cur.span};
      qrnog_pkg::SEG_EDGE_B,
      qrnog_pkg::SEG_EDGE_R,
      qrnog_pkg::SEG_EDGE_T,
      qrnog_pkg::SEG_EDGE_L:    addr = cur.offset;
      default:                  addr = cur.corner[5] + 8'd1;
    endcase
  end

  assign is_edge = cur.seg inside {[qrnog_pkg::SEG_EDGE_B : qrnog_pkg::SEG_EDGE_L]};
  // More nodes remain on this edge when the next step count plus one is below k.
  assign edge_more = is_edge && (({1'b0, cur.step} + 5'd2) < {1'b0, cur.span});

  // Next walk state.
  always_comb begin
    nxt      = cur;
    finish   = 1'b0;
    nxt.pos  = cur.pos + 8'd1;
    nxt.step = cur.step + 4'd1;
    case (cur.seg)
      qrnog_pkg::SEG_EDGE_B: nxt.offset = cur.offset + 8'd1;
      qrnog_pkg::SEG_EDGE_R: nxt.offset = cur.offset + n8;
      qrnog_pkg::SEG_EDGE_T: nxt.offset = cur.offset - 8'd1;
      qrnog_pkg::SEG_EDGE_L: nxt.offset = cur.offset - n8;
      default:               nxt.offset = cur.offset;
    endcase

    if (!edge_more) begin
      nxt.step = 4'd0;
      case (cur.seg)
        qrnog_pkg::SEG_CORNER_BL,
        qrnog_pkg::SEG_CORNER_BR,
        qrnog_pkg::SEG_CORNER_TR: nxt.seg = qrnog_pkg::seg_e'(seg_inc);
        qrnog_pkg::SEG_CORNER_TL,
        qrnog_pkg::SEG_EDGE_B,
        qrnog_pkg::SEG_EDGE_R,
        qrnog_pkg::SEG_EDGE_T: begin
          // Edges exist only when the ring spans two or more; otherwise the ring ends.
          if (cur.span >= 4'd2) begin
            nxt.seg    = qrnog_pkg::seg_e'(seg_inc);
            nxt.offset = cur.corner[3'(seg_inc[1:0]) + 3'd2];
          end else begin
            finish = 1'b1;
          end
        end
        qrnog_pkg::SEG_EDGE_L: begin
          if (cur.span == 4'd2) begin
            nxt.seg = qrnog_pkg::SEG_CENTER;
          end else begin
            finish = 1'b1;
          end
        end
        default: finish = 1'b1;
      endcase
    end

    // Ring done: either the walk is over or it moves to the next inner ring.
    if (finish) begin
      if (cur.span < 4'd3) begin
        nxt = restart_walk;
      end else begin
        nxt.span      = cur.span - 4'd2;
        nxt.seg       = qrnog_pkg::SEG_CORNER_BL;
        nxt.corner[0] = cur.corner[0] + ord8 + 8'd2;
        nxt.corner[1] = cur.corner[1] - ord8 - 8'd2;
        nxt.corner[2] = cur.corner[0] + ord8 + 8'd3;
        nxt.corner[3] = cur.corner[3] + ord8;
        nxt.corner[4] = cur.corner[1] - ord8 - 8'd3;
        nxt.corner[5] = cur.corner[5] - ord8;
      end
    end
  end

  assign walk_o           = nxt;
  assign res_o.seq_pos    = cur.pos;
  assign res_o.grid_index = addr;
  assign res_o.last       = finish && (cur.span < 4'd3);

endmodule

// ===== src/quad_ring_node_order_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_ring_node_order_generator_top: boundary-first node order generator
// Emits, one word per request, the ring-by-ring node order of a quad element
// with its sequence position, row-major grid index and a last flag.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o restart_i
//   out      output     out_valid_o/out_stall_i seq_pos_o, grid_index_o, last_o
//   cfg      APB        psel/penable/pready     paddr, pwdata, prdata
//
// Each request word goes through the step logic straight into the result
// register; the walk state updates in one pass, so a word is accepted every
// cycle unless the input stalls. The result register holds a word while
// out_stall_i is high, and the input stalls only while that held word is
// still waiting. Reset sets order 7 and the start of a fresh sequence.
// ----------------------------------------------------------------------------
module quad_ring_node_order_generator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        restart_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  seq_pos_o,
  output logic [7:0]  grid_index_o,
  output logic        last_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0]       order_q, order_d;
  qrnog_pkg::walk_t walk_q, walk_d;
  qrnog_pkg::walk_t walk_next;
  qrnog_pkg::res_t  res;
  qrnog_pkg::res_t  res_q;
  logic             out_valid_q, out_valid_d;
  logic             in_take;
  logic             cfg_wr;
  logic [3:0]       wr_val;

  // Step logic.
  qrnog_step u_step (
    .order_i   (order_q),
    .restart_i (restart_i),
    .walk_i    (walk_q),
    .walk_o    (walk_next),
    .res_o     (res)
  );

  // Handshake.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  // Configuration writes; a write clamps the order and restarts the walk.
  assign pready = 1'b1;
  assign prdata = {28'd0, order_q};
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);

  always_comb begin
    if (pwdata[3:0] == 4'd0) begin
      wr_val = 4'd1;
    end else if (pwdata[3:0] > qrnog_pkg::MAX_ORDER) begin
      wr_val = qrnog_pkg::MAX_ORDER;
    end else begin
      wr_val = pwdata[3:0];
    end
  end

  // Next state of order and walk.
  always_comb begin
    order_d = order_q;
    walk_d  = walk_q;
    if (cfg_wr) begin
      order_d = wr_val;
      walk_d  = qrnog_pkg::init_walk(wr_val);
    end else if (in_take) begin
      walk_d = walk_next;
    end
  end

  assign out_valid_d = in_take || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q     <= 4'd7;
      walk_q      <= qrnog_pkg::init_walk(4'd7);
      out_valid_q <= 1'b0;
    end else begin
      order_q     <= order_d;
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result word register.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign seq_pos_o    = res_q.seq_pos;
  assign grid_index_o = res_q.grid_index;
  assign last_o       = res_q.last;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the quad ring node order generator
// A short directed table covers reset, the smallest and largest orders, an
// order write of zero, wrap after the last node and restart. Random phases
// then set an order and walk through mostly whole sequences with occasional
// restarts, under random request gaps and result stalls. Every result word
// is checked against its table entry or a local model of the ring-by-ring walk.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [2:0] ORDER_ADDR   = 3'd0;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         RANDOM_WORDS = 1000;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e       kind;
    logic [3:0]      value;   // restart bit of a word row, order of a config row
    bit              typed;
    qrnog_pkg::res_t want;
  } row_t;

  typedef struct {
    bit              typed;
    qrnog_pkg::res_t want;
  } note_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        restart_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  seq_pos_o;
  logic [7:0]  grid_index_o;
  logic        last_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  quad_ring_node_order_generator_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .seq_pos_o    (seq_pos_o),
    .grid_index_o (grid_index_o),
    .last_o       (last_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Bench state: expected words, notes per request, counters.
  qrnog_pkg::res_t pending_nodes [$];
  note_t           node_notes [$];
  row_t            plan [$];
  int              requests_taken = 0;
  int              err_count = 0;
  int              cycles = 0;
  bit              calm = 1'b0;

  // Model of the walk state.
  logic [3:0]      ord_m;
  logic [3:0]      span_m;
  qrnog_pkg::seg_e seg_m;
  logic [3:0]      step_m;
  logic [7:0]      corner_m [6];
  logic [7:0]      pos_m;
  logic [7:0]      offset_m;

  function automatic void log_error(string msg);
    if (err_count < 10) begin
      $display("%0t: %s", $realtime, msg);
    end
    err_count++;
  endfunction

  // Load the outer ring of a fresh sequence for the current order.
  function automatic void load_outer_ring();
    logic [7:0] n;
    n           = {4'd0, ord_m} + 8'd1;
    span_m      = ord_m;
    seg_m       = qrnog_pkg::SEG_CORNER_BL;
    step_m      = 4'd0;
    pos_m       = 8'd0;
    offset_m    = 8'd0;
    corner_m[0] = 8'd0;
    corner_m[1] = n * n - 8'd1;
    corner_m[2] = 8'd1;
    corner_m[3] = 8'd2 * n - 8'd1;
    corner_m[4] = n * n - 8'd2;
    corner_m[5] = n * n - 8'd2 * n;
  endfunction

  // Move to segment p, skipping empty ones and stepping inward at the end
  // of a ring. Returns 1 when the whole sequence has been emitted.
  function automatic bit enter_segment(input int p);
    int k;
    k = span_m;
    forever begin
      if (p < 4) break;
      if (p < 8 && k >= 2) begin
        offset_m = corner_m[p - 2];
        break;
      end
      if (p == 8 && k == 2) break;
      if (p < 8) begin
        p++;
        continue;
      end
      // The ring is done: either the sequence ends or the next ring starts.
      if (k < 3) begin
        load_outer_ring();
        return 1'b1;
      end
      span_m      = k - 2;
      corner_m[0] = corner_m[0] + ord_m + 8'd2;
      corner_m[1] = corner_m[1] - ord_m - 8'd2;
      corner_m[2] = corner_m[0] + 8'd1;
      corner_m[3] = corner_m[3] + ord_m;
      corner_m[4] = corner_m[1] - 8'd1;
      corner_m[5] = corner_m[5] - ord_m;
      p = 0;
      break;
    end
    seg_m  = qrnog_pkg::seg_e'(p[3:0]);
    step_m = 4'd0;
    return 1'b0;
  endfunction

  // Next node of the walk for one accepted request word.
  function automatic qrnog_pkg::res_t walk_next_node(input logic rs);
    qrnog_pkg::res_t r;
    logic [7:0]      n;
    logic [7:0]      addr;
    int              k;
    bit              fin;
    if (rs) load_outer_ring();
    n         = {4'd0, ord_m} + 8'd1;
    k         = span_m;
    r.seq_pos = pos_m;
    case (seg_m)
      qrnog_pkg::SEG_CORNER_BL: addr = corner_m[0];
      qrnog_pkg::SEG_CORNER_BR: addr = corner_m[0] + span_m;
      qrnog_pkg::SEG_CORNER_TR: addr = corner_m[1];
      qrnog_pkg::SEG_CORNER_TL: addr = corner_m[1] - span_m;
      qrnog_pkg::SEG_EDGE_B: begin
        addr     = offset_m;
        offset_m = offset_m + 8'd1;
      end
      qrnog_pkg::SEG_EDGE_R: begin
        addr     = offset_m;
        offset_m = offset_m + n;
      end
      qrnog_pkg::SEG_EDGE_T: begin
        addr     = offset_m;
        offset_m = offset_m - 8'd1;
      end
      qrnog_pkg::SEG_EDGE_L: begin
        addr     = offset_m;
        offset_m = offset_m - n;
      end
      default: addr = corner_m[5] + 8'd1;
    endcase
    pos_m  = pos_m + 8'd1;
    step_m = step_m + 4'd1;
    if ((seg_m inside {[qrnog_pkg::SEG_EDGE_B : qrnog_pkg::SEG_EDGE_L]}) &&
        int'(step_m) + 1 < k) begin
      fin = 1'b0;
    end else begin
      fin = enter_segment(int'(seg_m) + 1);
    end
    r.grid_index = addr;
    r.last       = fin;
    return r;
  endfunction

  function automatic void add_row(row_kind_e kind, logic [3:0] value, bit typed,
                                  logic [7:0] sp, logic [7:0] gi, logic ls);
    row_t r;
    r.kind            = kind;
    r.value           = value;
    r.typed           = typed;
    r.want.seq_pos    = sp;
    r.want.grid_index = gi;
    r.want.last       = ls;
    plan.push_back(r);
  endfunction

  // Request gap: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result stall pattern, in runs of random length.
  int stall_run = 0;
  always @(negedge clk_i) begin
    int r;
    if (stall_run > 0) begin
      stall_run--;
    end else begin
      r = $urandom_range(0, 99);
      if (calm || r < 55) begin
        out_stall_i <= 1'b0;
        stall_run = $urandom_range(0, 6);
      end else if (r < 92) begin
        out_stall_i <= 1'b1;
        stall_run = $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b1;
        stall_run = $urandom_range(8, 30);
      end
    end
  end

  // Accepted request words: predict the node they produce.
  always @(posedge clk_i) begin
    note_t           nt;
    qrnog_pkg::res_t got;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      nt  = node_notes.pop_front();
      got = walk_next_node(restart_i);
      pending_nodes.push_back(nt.typed ? nt.want : got);
      requests_taken <= requests_taken + 1;
    end
  end

  // Accepted result words: compare with the oldest expected node.
  always @(posedge clk_i) begin
    qrnog_pkg::res_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_nodes.size() == 0) begin
        log_error($sformatf("unexpected word pos=%0d grid=%0d last=%0d",
                            seq_pos_o, grid_index_o, last_o));
      end else begin
        w = pending_nodes.pop_front();
        if (w.seq_pos !== seq_pos_o || w.grid_index !== grid_index_o ||
            w.last !== last_o) begin
          log_error($sformatf({"word mismatch: expected pos=%0d grid=%0d last=%0d,",
                               " got pos=%0d grid=%0d last=%0d"},
                              w.seq_pos, w.grid_index, w.last,
                              seq_pos_o, grid_index_o, last_o));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Send one request word after a random gap and wait until it is taken.
  task automatic send_word(input logic rs, input bit typed, input qrnog_pkg::res_t want);
    int    g;
    int    target;
    note_t nt;
    g = pick_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    nt.typed = typed;
    nt.want  = want;
    node_notes.push_back(nt);
    target = requests_taken + 1;
    in_valid_i <= 1'b1;
    restart_i  <= rs;
    do @(negedge clk_i); while (requests_taken != target);
  endtask

  // Stop requests and wait until every expected word has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_nodes.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write the order register while idle, then read it back.
  task automatic write_order(input logic [3:0] v);
    logic [31:0] want_rd;
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ORDER_ADDR;
    pwdata  <= {28'd0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // Order zero is taken as one; a write also restarts the walk.
    ord_m = (v == 4'd0) ? 4'd1 : v;
    load_outer_ring();
    want_rd = {28'd0, ord_m};
    @(negedge clk_i);
    psel <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want_rd) begin
      log_error($sformatf("order read back: expected %0d, got %0d", want_rd, prdata));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Main sequence: reset, directed table, random phases, end of run.
  initial begin
    int              total;
    int              ph;
    int              cnt;
    int              sq;
    int              ord_pick;
    qrnog_pkg::res_t none;
    in_valid_i  = 1'b0;
    restart_i   = 1'b0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = ORDER_ADDR;
    pwdata      = 32'd0;
    rst_ni      = 1'b0;
    none        = '0;
    ord_m       = 4'd7;
    load_outer_ring();

    // Reset state, restart, order zero, order one with wrap.
    add_row(ROW_WORD, 4'd0, 1'b1, 8'd0, 8'd0, 1'b0);
    add_row(ROW_WORD, 4'd0, 1'b0, 8'd0, 8'd0, 1'b0);
    add_row(ROW_WORD, 4'd1, 1'b1, 8'd0, 8'd0, 1'b0);
    add_row(ROW_CFG,  4'd0, 1'b0, 8'd0, 8'd0, 1'b0);
    add_row(ROW_WORD, 4'd0, 1'b1, 8'd0, 8'd0, 1'b0);
    add_row(ROW_WORD, 4'd0, 1'b1, 8'd1, 8'd1, 1'b0);
    add_row(ROW_WORD, 4'd0, 1'b1, 8'd2, 8'd3, 1'b0);
    add_row(ROW_WORD, 4'd0, 1'b1, 8'd3, 8'd2, 1'b1);
    add_row(ROW_WORD, 4'd0, 1'b1, 8'd0, 8'd0, 1'b0);
    // Largest order.
    add_row(ROW_CFG,  4'd15, 1'b0, 8'd0, 8'd0, 1'b0);
    add_row(ROW_WORD, 4'd0, 1'b1, 8'd0, 8'd0, 1'b0);
    add_row(ROW_WORD, 4'd0, 1'b1, 8'd1, 8'd15, 1'b0);
    add_row(ROW_WORD, 4'd1, 1'b1, 8'd0, 8'd0, 1'b0);
    add_row(ROW_WORD, 4'd0, 1'b0, 8'd0, 8'd0, 1'b0);
    // Order two: corners, one node per edge, then the center.
    add_row(ROW_CFG,  4'd2, 1'b0, 8'd0, 8'd0, 1'b0);
    add_row(ROW_WORD, 4'd0, 1'b1, 8'd0, 8'd0, 1'b0);
    add_row(ROW_WORD, 4'd0, 1'b1, 8'd1, 8'd2, 1'b0);
    add_row(ROW_WORD, 4'd0, 1'b1, 8'd2, 8'd8, 1'b0);
    add_row(ROW_WORD, 4'd0, 1'b1, 8'd3, 8'd6, 1'b0);
    add_row(ROW_WORD, 4'd0, 1'b1, 8'd4, 8'd1, 1'b0);
    add_row(ROW_WORD, 4'd0, 1'b1, 8'd5, 8'd5, 1'b0);
    add_row(ROW_WORD, 4'd0, 1'b1, 8'd6, 8'd7, 1'b0);
    add_row(ROW_WORD, 4'd0, 1'b1, 8'd7, 8'd3, 1'b0);
    add_row(ROW_WORD, 4'd0, 1'b1, 8'd8, 8'd4, 1'b1);
    add_row(ROW_WORD, 4'd0, 1'b1, 8'd0, 8'd0, 1'b0);
    add_row(ROW_WORD, 4'd0, 1'b0, 8'd0, 8'd0, 1'b0);
    add_row(ROW_WORD, 4'd1, 1'b1, 8'd0, 8'd0, 1'b0);

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_order(plan[i].value);
      end else begin
        send_word(plan[i].value[0], plan[i].typed, plan[i].want);
      end
    end

    // Random phases: the first ones hit the largest, smallest and zero
    // orders, later ones pick any order. Mostly whole sequences.
    total = 0;
    ph    = 0;
    while (total < RANDOM_WORDS) begin
      if (ph == 0) ord_pick = 15;
      else if (ph == 1) ord_pick = 1;
      else if (ph == 2) ord_pick = 0;
      else ord_pick = $urandom_range(0, 15);
      write_order(ord_pick[3:0]);
      calm = (ph % 4 == 3);
      sq   = (int'(ord_m) + 1) * (int'(ord_m) + 1);
      cnt  = sq + $urandom_range(0, sq) + $urandom_range(0, 3);
      repeat (cnt) begin
        send_word($urandom_range(0, 31) == 0, 1'b0, none);
        total++;
      end
      ph++;
    end
    calm = 1'b0;

    drain();
    repeat (8) @(negedge clk_i);
    if (pending_nodes.size() != 0) begin
      log_error($sformatf("%0d expected words never arrived", pending_nodes.size()));
    end
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/qrnog_pkg.sv
src/qrnog_step.sv
src/quad_ring_node_order_generator_top.sv
bench/testbench.sv
